FILE: hdl/lru_page_replacement_core_defines.svh
// Assertion macros shared by the LRU replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on clk, off while arst_n is low.
`define LRUPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a property on clk at every edge, reset included.
`define LRUPR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LRUPR_ASSERT(lbl, prop, msg)
`define LRUPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/lrupr_pkg.sv
package lrupr_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 20;
	localparam int IDX_W     = $clog2(FRAMES);
	localparam int RANK_W    = $clog2(FRAMES);
	localparam int CFG_W     = 4;
	localparam int CNT_W     = 32;
	localparam int OUT_IDX_W = 3;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [CFG_W-1:0]     used_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		logic [19:0] page_number;
		logic        end_of_string;
	} lrupr_req_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  frame_index;
		logic        evicted_valid;
		logic [19:0] evicted_page;
		logic [31:0] fault_count;
	} lrupr_rsp_t;

	// Partial search result handed from cell to cell.
	typedef struct packed {
		logic  hit_found;
		idx_t  hit_idx;
		rank_t hit_rank;
		logic  empty_found;
		idx_t  empty_idx;
		rank_t best_rank;
		idx_t  best_idx;
		page_t best_page;
	} lrupr_chain_t;

	// Update broadcast to every cell.
	typedef struct packed {
		logic  en;
		logic  clear;
		idx_t  target;
		logic  was_valid;
		rank_t old_rank;
		logic  fill;
		page_t page;
	} lrupr_upd_t;

endpackage

FILE: hdl/lru_page_replacement_core.sv
// LRU page replacement over a row of FRAMES page-frame cells.
// Command channel: drive req and pulse start; a reference is taken at a rising
// edge with start high and busy low. busy stays low, so a reference may be
// issued in every cycle.
// Result channel: done is high for one cycle with rsp; rsp must be taken in that
// cycle, the receiver cannot stall it. Results come in reference order.
// Pipeline: an accepted reference is registered into valid_s1 and req_s1; its
// search result is then registered into done and rsp. Throughput: one reference
// per cycle, set by the single search-and-update pass: every cell compares in
// parallel, the partial search result ripples down the cell row in the same
// cycle, and the chosen frame update is broadcast back to all cells at the next edge.
// Configuration: cfg_we with cfg_data writes frames_in_use (0 acts as 1, above
// FRAMES acts as FRAMES); write it only while no reference is in flight.
// Reset: all frames empty, ranks and fault count zero, frames_in_use = 8.
// A reference with end_of_string set gets its result, then all frames and the
// fault count are cleared.
`include "lru_page_replacement_core_defines.svh"

module lru_page_replacement_core
	import lrupr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  lrupr_req_t  req,
	input  logic        cfg_we,
	input  used_t       cfg_data,
	output logic        done,
	output lrupr_rsp_t  rsp
);

	logic         valid_s1;
	lrupr_req_t   req_s1;
	used_t        used_q;
	lrupr_upd_t   upd;
	lrupr_chain_t chain [FRAMES+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			used_q   <= CFG_W'(FRAMES);
		end else begin
			valid_s1 <= start && !busy;
			// clamp the frame count once, at the write
			if (cfg_we) begin
				priority if (cfg_data == '0) begin
					used_q <= CFG_W'(1);
				end else if (cfg_data > CFG_W'(FRAMES)) begin
					used_q <= CFG_W'(FRAMES);
				end else begin
					used_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(i)),
			.used      (used_q),
			.page      (PAGE_BITS'(req_s1.page_number)),
			.upd       (upd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	lrupr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.chain    (chain[FRAMES]),
		.upd      (upd),
		.done     (done),
		.rsp      (rsp)
	);

	`LRUPR_ASSERT(a_done_latency, done |-> $past(start && !busy, 2), "result without a transfer")
	`LRUPR_ASSERT(a_used_range, used_q != '0 && used_q <= CFG_W'(FRAMES), "frame count out of range")
	`LRUPR_ASSERT(a_idx_in_use, done |-> CFG_W'(rsp.frame_index) < used_q, "frame outside in-use range")

endmodule

FILE: hdl/lrupr_cell.sv
`include "lru_page_replacement_core_defines.svh"

module lrupr_cell
	import lrupr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  idx_t         idx,
	input  used_t        used,
	input  page_t        page,
	input  lrupr_upd_t   upd,
	input  lrupr_chain_t chain_in,
	output lrupr_chain_t chain_out
);

	page_t page_q;
	logic  valid_q;
	rank_t rank_q;
	logic  in_use;
	logic  match;
	logic  sel;

	assign in_use = CFG_W'(idx) < used;
	assign match  = in_use && valid_q && (page_q == page);
	assign sel    = (upd.target == idx);

	always_comb begin
		chain_out = chain_in;
		// lowest matching frame wins: keep an earlier hit
		if (match && !chain_in.hit_found) begin
			chain_out.hit_found = 1'b1;
			chain_out.hit_idx   = idx;
			chain_out.hit_rank  = rank_q;
		end
		// highest empty frame wins: override an earlier one
		if (in_use && !valid_q) begin
			chain_out.empty_found = 1'b1;
			chain_out.empty_idx   = idx;
		end
		if (in_use && rank_q >= chain_in.best_rank) begin
			chain_out.best_rank = rank_q;
			chain_out.best_idx  = idx;
			chain_out.best_page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			priority if (upd.clear) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (sel) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (!upd.was_valid || rank_q < upd.old_rank)) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.fill && sel) begin
			page_q <= upd.page;
		end
	end

	`LRUPR_ASSERT(a_touch_mru, upd.en && !upd.clear && sel |=> valid_q && rank_q == '0, "touched frame is not most recent")
	`LRUPR_ASSERT(a_clear_empty, upd.en && upd.clear |=> !valid_q && rank_q == '0, "frame not cleared at end of string")
	`LRUPR_ASSERT_ALWAYS(a_empty_rank, !valid_q |-> rank_q == '0, "empty frame holds a nonzero rank")

endmodule

FILE: hdl/lrupr_ctrl.sv
`include "lru_page_replacement_core_defines.svh"

module lrupr_ctrl
	import lrupr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  lrupr_req_t   req_s1,
	input  lrupr_chain_t chain,
	output lrupr_upd_t   upd,
	output logic         done,
	output lrupr_rsp_t   rsp
);

	cnt_t       cnt_q;
	cnt_t       cnt_nxt;
	logic       evict;
	idx_t       target;
	rank_t      old_rank;
	lrupr_rsp_t rsp_q;
	logic       done_q;

	always_comb begin
		priority if (chain.hit_found) begin
			target   = chain.hit_idx;
			old_rank = chain.hit_rank;
		end else if (chain.empty_found) begin
			target   = chain.empty_idx;
			old_rank = chain.best_rank;
		end else begin
			target   = chain.best_idx;
			old_rank = chain.best_rank;
		end
	end

	assign evict = !chain.hit_found && !chain.empty_found;

	// saturate the fault count
	assign cnt_nxt = (!chain.hit_found && cnt_q != '1) ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		upd.en        = valid_s1;
		upd.clear     = req_s1.end_of_string;
		upd.target    = target;
		upd.was_valid = chain.hit_found || !chain.empty_found;
		upd.old_rank  = old_rank;
		upd.fill      = !chain.hit_found;
		upd.page      = PAGE_BITS'(req_s1.page_number);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				cnt_q <= req_s1.end_of_string ? '0 : cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.hit           <= chain.hit_found;
			rsp_q.frame_index   <= OUT_IDX_W'(target);
			rsp_q.evicted_valid <= evict;
			rsp_q.evicted_page  <= evict ? 20'(chain.best_page) : '0;
			rsp_q.fault_count   <= 32'(cnt_nxt);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`LRUPR_ASSERT(a_clear_count, valid_s1 && req_s1.end_of_string |=> cnt_q == '0, "fault count not cleared")
	`LRUPR_ASSERT(a_miss_counts, valid_s1 && !chain.hit_found && !req_s1.end_of_string |=> cnt_q != '0, "miss not counted")
	`LRUPR_ASSERT(a_hit_no_evict, done_q && rsp_q.hit |-> !rsp_q.evicted_valid, "hit reports an eviction")

endmodule
